@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`define ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define ASSERT_NEXT(label, pre, post, msg)
`define ASSERT_SAME(label, pre, post, msg)
`endif
`endif

@@ src/modexp_pkg.sv @@
// Package for the modular exponentiation block: widths, register codes,
// reset values and the sequencer state type. No dependencies.
package modexp_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = CFG_IDX_W'(1);

    localparam logic [WIDTH-1:0] MODULUS_RESET  = WIDTH'(119);
    localparam logic [WIDTH-1:0] EXPONENT_RESET = WIDTH'(5);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_SQUARE = 5'b00100,
        ST_MULT   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

endpackage

@@ src/modexp_step.sv @@
// One bit step of the shared modular unit: (2*acc + cin) mod m, then
// optionally + x mod m. Depends on modexp_pkg. acc, x below m; m nonzero.
module modexp_step
(
    input  logic [modexp_pkg::WIDTH-1:0] acc,
    input  logic [modexp_pkg::WIDTH-1:0] x,
    input  logic [modexp_pkg::WIDTH-1:0] modulus,
    input  logic                         cin,
    input  logic                         add_en,
    output logic [modexp_pkg::WIDTH-1:0] result
);

    logic [modexp_pkg::WIDTH:0]   dbl;
    logic [modexp_pkg::WIDTH:0]   dbl_red;
    logic [modexp_pkg::WIDTH:0]   sum;
    logic [modexp_pkg::WIDTH:0]   mod_ext;

    always_comb
    begin
        mod_ext = {1'b0, modulus};
        dbl     = {acc, cin};
        dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
        sum     = {1'b0, dbl_red[modexp_pkg::WIDTH-1:0]} + {1'b0, x};
        if (add_en && (sum >= mod_ext))
        begin
            sum = sum - mod_ext;
        end
        else if (!add_en)
        begin
            sum = dbl_red;
        end
        result = sum[modexp_pkg::WIDTH-1:0];
    end

endmodule

@@ src/modular_exponentiation_top.sv @@
// Modular exponentiation, left-to-right square-and-multiply, one shared
// bit-serial modular step unit. The base is first reduced mod the modulus,
// then each exponent bit, MSB first, takes a square and, if set, a multiply;
// a zero exponent or modulus goes straight to the result. One item at a
// time: s_tready returns with m_tvalid. rst_n clears control and loads
// modulus 119, exponent 5.
`include "assert_macros.svh"

module modular_exponentiation_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [modexp_pkg::WIDTH-1:0]         s_tdata,   // [31:0] base
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [modexp_pkg::WIDTH-1:0]         m_tdata,   // [31:0] power
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [modexp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [modexp_pkg::WIDTH-1:0]         cfg_data
);

    localparam int W = modexp_pkg::WIDTH;
    localparam int CW = modexp_pkg::CNT_W;

    modexp_pkg::state_t state_reg, state_next;
    logic [W-1:0]  modulus_reg, modulus_next;
    logic [W-1:0]  exponent_reg, exponent_next;
    logic [W-1:0]  base_reg, base_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  prod_reg, prod_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ebit_reg, ebit_next;
    logic          out_valid_reg, out_valid_next;
    logic [W-1:0]  out_data_reg, out_data_next;

    logic          step_cin;
    logic          step_add;
    logic [W-1:0]  step_result;
    logic          in_beat;
    logic          job_start;
    logic          mul_busy;
    logic          done_load;

    modexp_step u_step
    (
        .acc     (prod_reg),
        .x       (acc_reg),
        .modulus (modulus_reg),
        .cin     (step_cin),
        .add_en  (step_add),
        .result  (step_result)
    );

    assign s_tready  = (state_reg == modexp_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign in_beat   = s_tvalid && s_tready;
    assign job_start = in_beat && (exponent_reg != '0) && (modulus_reg != '0);
    assign mul_busy  = (state_reg == modexp_pkg::ST_SQUARE) || (state_reg == modexp_pkg::ST_MULT);
    assign done_load = (state_reg == modexp_pkg::ST_DONE) && !out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        modulus_next   = modulus_reg;
        exponent_next  = exponent_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        ebit_next      = ebit_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        step_cin       = 1'b0;
        step_add       = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            if (cfg_index == modexp_pkg::CFG_MODULUS)
            begin
                modulus_next = cfg_data;
            end
            else if (cfg_index == modexp_pkg::CFG_EXPONENT)
            begin
                exponent_next = cfg_data;
            end
        end

        unique case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    base_next = s_tdata;
                    prod_next = '0;
                    cnt_next  = CW'(W - 1);
                    ebit_next = CW'(W - 1);
                    if (exponent_reg == '0)
                    begin
                        acc_next   = W'(1);
                        state_next = modexp_pkg::ST_DONE;
                    end
                    else if (modulus_reg == '0)
                    begin
                        acc_next   = '0;
                        state_next = modexp_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = modexp_pkg::ST_REDUCE;
                    end
                end
            end
            modexp_pkg::ST_REDUCE:
            begin
                step_cin  = base_reg[cnt_reg];
                prod_next = step_result;
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    base_next  = step_result;
                    acc_next   = (modulus_reg == W'(1)) ? '0 : W'(1);
                    prod_next  = '0;
                    state_next = modexp_pkg::ST_SQUARE;
                end
            end
            modexp_pkg::ST_SQUARE, modexp_pkg::ST_MULT:
            begin
                step_add  = (state_reg == modexp_pkg::ST_SQUARE) ? acc_reg[cnt_reg]
                                                                  : base_reg[cnt_reg];
                prod_next = step_result;
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    acc_next  = step_result;
                    prod_next = '0;
                    if ((state_reg == modexp_pkg::ST_SQUARE) && exponent_reg[ebit_reg])
                    begin
                        state_next = modexp_pkg::ST_MULT;
                    end
                    else if (ebit_reg == '0)
                    begin
                        state_next = modexp_pkg::ST_DONE;
                    end
                    else
                    begin
                        ebit_next  = ebit_reg - CW'(1);
                        state_next = modexp_pkg::ST_SQUARE;
                    end
                end
            end
            modexp_pkg::ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = modexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= modexp_pkg::ST_IDLE;
            modulus_reg   <= modexp_pkg::MODULUS_RESET;
            exponent_reg  <= modexp_pkg::EXPONENT_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            ebit_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            exponent_reg  <= exponent_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            ebit_reg      <= ebit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    `ASSERT_NEXT(a_start_reduce, job_start, state_reg == modexp_pkg::ST_REDUCE, "no reduce")
    `ASSERT_SAME(a_prod_below_mod, mul_busy, prod_reg < modulus_reg, "partial product not reduced")
    `ASSERT_NEXT(a_done_loads, done_load, m_tvalid && s_tready, "result beat not loaded")

endmodule

@@ tb/modular_exponentiation_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for modular_exponentiation_top: streams bases in and checks
// every power against a predictor kept in a scoreboard class. Needs modexp_pkg and the RTL.
module modular_exponentiation_top_test;

    localparam int IDLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 2200;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_ITEMS   = 30;

    typedef logic [modexp_pkg::WIDTH-1:0] word_t;
    typedef logic [modexp_pkg::CFG_IDX_W-1:0] cfg_idx_t;

    typedef struct {
        word_t modulus;
        word_t exponent;
        word_t base;
    } directed_case_t;

    class power_board;
        word_t modulus;
        word_t exponent;
        word_t power_q[$];
        int    errors;

        function new();
            modulus  = modexp_pkg::MODULUS_RESET;
            exponent = modexp_pkg::EXPONENT_RESET;
            errors   = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, word_t value);
            case (idx)
                modexp_pkg::CFG_MODULUS:  modulus = value;
                modexp_pkg::CFG_EXPONENT: exponent = value;
                default: ;
            endcase
        endfunction

        // square-and-multiply over all exponent bits, MSB first
        function word_t power_of(word_t base);
            bit [63:0] m;
            bit [63:0] b;
            bit [63:0] acc;
            if (exponent == '0)
                return word_t'(1);
            if (modulus == '0)
                return '0;
            m   = 64'(modulus);
            b   = 64'(base) % m;
            acc = 64'd1 % m;
            for (int k = modexp_pkg::WIDTH - 1; k >= 0; k--)
            begin
                acc = (acc * acc) % m;
                if (exponent[k])
                    acc = (acc * b) % m;
            end
            return acc[modexp_pkg::WIDTH-1:0];
        endfunction

        function void note_base(word_t base);
            power_q.push_back(power_of(base));
        endfunction

        function void check_power(word_t actual);
            word_t want;
            if (power_q.size() == 0)
            begin
                $error("power: no result expected, got %h", actual);
                errors++;
            end
            else
            begin
                want = power_q.pop_front();
                if (want !== actual)
                begin
                    $error("power: expected %h, actual %h", want, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return power_q.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    word_t                s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    word_t                m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_idx_t             cfg_index = modexp_pkg::CFG_MODULUS;
    word_t                cfg_data = '0;

    power_board board = new();
    int         idle_max = 14;
    int         stall_cycles = 0;

    modular_exponentiation_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // valid is left high after a beat; the next call either lowers it or moves on
    task automatic send_base(word_t base);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= base;
        do @(posedge clk); while (!s_tready);
        board.note_base(base);
    endtask

    task automatic drain_powers();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, word_t value, bit hold);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, value);
        if (!hold)
            cfg_valid <= 1'b0;
    endtask

    task automatic configure(word_t modulus, word_t exponent);
        drain_powers();
        write_reg(modexp_pkg::CFG_MODULUS, modulus, 1'b1);
        write_reg(modexp_pkg::CFG_EXPONENT, exponent, 1'b0);
    endtask

    function automatic word_t pick_modulus();
        case ($urandom_range(0, 11))
            0: return word_t'(2);
            1: return '1;
            2: return word_t'($urandom_range(2, 255));
            3: return word_t'(1) << $urandom_range(1, modexp_pkg::WIDTH - 1);
            4: return word_t'($urandom_range(0, 1));
            5: return word_t'($urandom_range(3, 65535));
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic word_t pick_exponent();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return word_t'($urandom_range(1, 15));
            3: return word_t'(1) << $urandom_range(0, modexp_pkg::WIDTH - 1);
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic word_t pick_base(word_t modulus);
        case ($urandom_range(0, 9))
            0: return word_t'($urandom_range(0, 3));
            1: return '1;
            2: return modulus - word_t'($urandom_range(0, 3));
            3: return modulus + word_t'($urandom_range(0, 3));
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic add_case(ref directed_case_t cases[$], input word_t m, word_t e, word_t b);
        directed_case_t c;
        c.modulus  = m;
        c.exponent = e;
        c.base     = b;
        cases.push_back(c);
    endtask

    initial
    begin
        while (!rst_n) @(posedge clk);
        forever
        begin
            int stall;
            stall = $urandom_range(0, idle_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            board.check_power(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= IDLE_LIMIT)
            begin
                $display("[modular_exponentiation_top] ERROR");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        directed_case_t cases[$];
        word_t          modulus;
        word_t          exponent;

        // reset values, base around the modulus and at the extremes
        add_case(cases, 119, 5, 0);
        add_case(cases, 119, 5, 1);
        add_case(cases, 119, 5, 118);
        add_case(cases, 119, 5, 119);
        add_case(cases, 119, 5, 120);
        add_case(cases, 119, 5, 32'hFFFF_FFFF);
        add_case(cases, 119, 5, 2);
        // widest modulus and exponent
        add_case(cases, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        add_case(cases, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_case(cases, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        // zero exponent
        add_case(cases, 1000003, 0, 0);
        add_case(cases, 1000003, 0, 12345);
        // modulus one
        add_case(cases, 1, 32'hDEAD_BEEF, 0);
        add_case(cases, 1, 32'hDEAD_BEEF, 5);
        // modulus zero, with and without exponent
        add_case(cases, 0, 7, 9);
        add_case(cases, 0, 7, 32'hFFFF_FFFF);
        add_case(cases, 0, 0, 3);
        // smallest modulus above one
        add_case(cases, 2, 32'h8000_0001, 3);
        add_case(cases, 2, 32'h8000_0001, 4);
        // largest 32-bit prime, exponent p-1
        add_case(cases, 32'hFFFF_FFFB, 32'hFFFF_FFFA, 2);
        add_case(cases, 32'hFFFF_FFFB, 32'hFFFF_FFFA, 32'h1234_5678);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (cases[i])
        begin
            if (cases[i].modulus !== board.modulus || cases[i].exponent !== board.exponent)
                configure(cases[i].modulus, cases[i].exponent);
            send_base(cases[i].base);
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            modulus  = pick_modulus();
            exponent = pick_exponent();
            configure(modulus, exponent);
            idle_max = (p == 3 || $urandom_range(0, 3) == 0) ? 0 : 14;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 15) == 0)
                    drain_powers();
                send_base(pick_base(modulus));
            end
        end

        drain_powers();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("[modular_exponentiation_top] OK");
        else
            $display("[modular_exponentiation_top] ERROR");
        $finish;
    end

endmodule

@@ modular_exponentiation_top.f @@
+incdir+src
src/modexp_pkg.sv
src/modexp_step.sv
src/modular_exponentiation_top.sv
tb/modular_exponentiation_top_test.sv
